// ===== sv/im2col_patch_unroller_macros.svh =====
// Assertion macros shared by the unroller RTL.
`ifndef IM2COL_PATCH_UNROLLER_MACROS_SVH
`define IM2COL_PATCH_UNROLLER_MACROS_SVH
`ifndef SYNTH
`define IPU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipu assertion failed");
`define IPU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipu assertion failed");
`else
`define IPU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IPU_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/ipu_pkg.sv =====
package ipu_pkg;

    localparam int STORE_WORDS   = 4096;
    localparam int ADDR_BITS     = $clog2(STORE_WORDS);
    localparam int LOAD_CNT_BITS = ADDR_BITS + 1;
    localparam int DATA_BITS     = 32;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 7;
    localparam int DIV_STEPS     = 7;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_IN_HEIGHT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IN_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_IN_CHANNELS = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_KER_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_KER_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE      = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_PADDING     = 3'd6;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_EMIT    = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef struct packed {
        req_t        req;
        logic [31:0] pixel;
    } cmd_t;

    typedef struct packed {
        logic [6:0] in_height;
        logic [6:0] in_width;
        logic [4:0] in_channels;
        logic [4:0] ker_height;
        logic [4:0] ker_width;
        logic [4:0] stride;
        logic [2:0] padding;
    } cfg_t;

    typedef struct packed {
        logic        busy;
        logic        empty;
        logic [4:0]  stride_eff;
        logic [6:0]  out_h;
        logic [6:0]  out_w;
        logic [12:0] plane;
    } geom_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_PROD,
        ST_ADDR,
        ST_OUT
    } back_state_t;

endpackage

// ===== sv/ipu_ram.sv =====
module ipu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ipu_front.sv =====
module ipu_front (
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        req_type,
    input  logic [31:0]       pixel,
    input  logic              geom_busy,
    input  logic              fifo_full,
    output logic              push,
    output ipu_pkg::cmd_t     entry
);

    ipu_pkg::req_t req;

    assign req      = ipu_pkg::req_t'(req_type);
    assign in_ready = !fifo_full && !geom_busy;

    // drop the unused request code here, it never reaches the queue
    always_comb
    begin
        case (req)
            ipu_pkg::REQ_LOAD,
            ipu_pkg::REQ_EMIT,
            ipu_pkg::REQ_RESTART: push = in_valid && in_ready;
            default:              push = 1'b0;
        endcase
    end

    assign entry.req   = req;
    assign entry.pixel = pixel;

endmodule

// ===== sv/ipu_fifo.sv =====
`include "im2col_patch_unroller_macros.svh"

module ipu_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ipu_pkg::cmd_t wr_entry,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output ipu_pkg::cmd_t head
);

    ipu_pkg::cmd_t                     mem_reg [ipu_pkg::FIFO_DEPTH];
    logic [ipu_pkg::FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ipu_pkg::FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ipu_pkg::FIFO_PTR_BITS:0]   count_reg, count_next;
    logic                              do_pop;

    assign full       = count_reg == (ipu_pkg::FIFO_PTR_BITS+1)'(ipu_pkg::FIFO_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    `IPU_ASSERT_IMP(a_fifo_bound, clk, rst_n, 1'b1, count_reg <= (ipu_pkg::FIFO_PTR_BITS+1)'(ipu_pkg::FIFO_DEPTH))
    `IPU_ASSERT_IMP(a_fifo_no_overrun, clk, rst_n, full, !push)

endmodule

// ===== sv/ipu_geom.sv =====
module ipu_geom (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ipu_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [ipu_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output ipu_pkg::cfg_t                      cfg,
    output ipu_pkg::geom_t                     geom
);

    ipu_pkg::cfg_t cfg_reg;
    logic          busy_reg;
    logic          load_reg;
    logic [2:0]    step_reg;
    logic [6:0]    numh_reg, numh_next;
    logic [6:0]    numw_reg, numw_next;
    logic [4:0]    remh_reg, remh_next;
    logic [4:0]    remw_reg, remw_next;
    logic [12:0]   plane_reg;

    logic [4:0]    s_eff;
    logic [7:0]    hp, wp;
    logic [6:0]    dh, dw;
    logic [5:0]    remh_sh, remw_sh;
    logic          geh, gew;
    logic          cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign s_eff = (cfg_reg.stride == 5'd0) ? 5'd1 : cfg_reg.stride;
    assign hp    = 8'(cfg_reg.in_height) + 8'({cfg_reg.padding, 1'b0});
    assign wp    = 8'(cfg_reg.in_width) + 8'({cfg_reg.padding, 1'b0});
    assign dh    = 7'(hp - 8'(cfg_reg.ker_height));
    assign dw    = 7'(wp - 8'(cfg_reg.ker_width));

    // one restoring-division step per cycle for both output extents, while the divider is busy
    always_comb
    begin
        remh_sh   = {remh_reg, numh_reg[6]};
        remw_sh   = {remw_reg, numw_reg[6]};
        geh       = remh_sh >= 6'(s_eff);
        gew       = remw_sh >= 6'(s_eff);
        remh_next = geh ? 5'(remh_sh - 6'(s_eff)) : remh_sh[4:0];
        remw_next = gew ? 5'(remw_sh - 6'(s_eff)) : remw_sh[4:0];
        numh_next = {numh_reg[5:0], geh};
        numw_next = {numw_reg[5:0], gew};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.in_height   <= 7'd8;
            cfg_reg.in_width    <= 7'd8;
            cfg_reg.in_channels <= 5'd1;
            cfg_reg.ker_height  <= 5'd3;
            cfg_reg.ker_width   <= 5'd3;
            cfg_reg.stride      <= 5'd1;
            cfg_reg.padding     <= 3'd0;
            busy_reg            <= 1'b1;
            load_reg            <= 1'b1;
            step_reg            <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                ipu_pkg::REG_IN_HEIGHT:   cfg_reg.in_height   <= cfg_data;
                ipu_pkg::REG_IN_WIDTH:    cfg_reg.in_width    <= cfg_data;
                ipu_pkg::REG_IN_CHANNELS: cfg_reg.in_channels <= cfg_data[4:0];
                ipu_pkg::REG_KER_HEIGHT:  cfg_reg.ker_height  <= cfg_data[4:0];
                ipu_pkg::REG_KER_WIDTH:   cfg_reg.ker_width   <= cfg_data[4:0];
                ipu_pkg::REG_STRIDE:      cfg_reg.stride      <= cfg_data[4:0];
                ipu_pkg::REG_PADDING:     cfg_reg.padding     <= cfg_data[2:0];
                default:                  ;
            endcase
            busy_reg <= 1'b1;
            load_reg <= 1'b1;
        end
        else if (load_reg)
        begin
            load_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 3'd1;
            if (step_reg == 3'(ipu_pkg::DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_reg)
        begin
            numh_reg  <= dh;
            numw_reg  <= dw;
            remh_reg  <= '0;
            remw_reg  <= '0;
            plane_reg <= 13'(cfg_reg.in_height) * 13'(cfg_reg.in_width);
        end
        else if (busy_reg)
        begin
            numh_reg <= numh_next;
            numw_reg <= numw_next;
            remh_reg <= remh_next;
            remw_reg <= remw_next;
        end
    end

    assign cfg             = cfg_reg;
    assign geom.busy       = busy_reg;
    assign geom.empty      = cfg_reg.in_channels == 5'd0 || cfg_reg.ker_height == 5'd0 ||
                             cfg_reg.ker_width == 5'd0 ||
                             hp < 8'(cfg_reg.ker_height) || wp < 8'(cfg_reg.ker_width);
    assign geom.stride_eff = s_eff;
    assign geom.out_h      = numh_reg + 7'd1;
    assign geom.out_w      = numw_reg + 7'd1;
    assign geom.plane      = plane_reg;

endmodule

// ===== sv/ipu_back.sv =====
`include "im2col_patch_unroller_macros.svh"

module ipu_back (
    input  logic           clk,
    input  logic           rst_n,
    input  ipu_pkg::cfg_t  cfg,
    input  ipu_pkg::geom_t geom,
    input  logic           head_valid,
    input  ipu_pkg::cmd_t  head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    value,
    output logic [12:0]    out_row,
    output logic [11:0]    out_col,
    output logic           is_pad,
    output logic           row_last,
    output logic           all_last
);

    ipu_pkg::back_state_t state_reg, state_next;

    logic [ipu_pkg::LOAD_CNT_BITS-1:0] load_cnt_reg, load_cnt_next;
    logic [6:0] win_row_reg, win_row_next;
    logic [6:0] win_col_reg, win_col_next;
    logic [3:0] chan_reg, chan_next;
    logic [3:0] kr_reg, kr_next;
    logic [3:0] kc_reg, kc_next;
    logic       done_reg, done_next;
    logic       out_valid_reg;

    // captured element and pipeline registers
    logic [6:0]  cap_row_reg, cap_col_reg;
    logic [3:0]  cap_chan_reg, cap_kr_reg, cap_kc_reg;
    logic        row_last_reg, all_last_reg;
    logic [11:0] prod_r_reg, prod_c_reg;
    logic [13:0] orow_reg;
    logic [8:0]  cm_reg;
    logic [16:0] cplane_reg;
    logic [13:0] r_reg, c_reg;
    logic [12:0] row_sum_reg;
    logic [9:0]  col_sum_reg;
    logic        inside_reg;
    logic [13:0] rw_reg;
    logic [6:0]  c7_reg;
    logic [11:0] col_idx_reg;
    logic        zero_reg;

    logic [31:0] value_reg;
    logic [12:0] out_row_reg;
    logic [11:0] out_col_reg;
    logic        is_pad_reg, row_last_out_reg, all_last_out_reg;

    logic        emit_go, is_row_last, is_all_last, bad, can_load;
    logic [4:0]  kc_inc, kr_inc, chan_inc;
    logic [6:0]  win_col_inc;
    logic        ram_we, ram_re, out_load, out_free;
    logic [17:0] addr;
    logic [ipu_pkg::DATA_BITS-1:0] rdata;
    logic        inside_now;

    assign can_load = load_cnt_reg < ipu_pkg::LOAD_CNT_BITS'(ipu_pkg::STORE_WORDS);

    assign bad = done_reg || win_row_reg >= geom.out_h || win_col_reg >= geom.out_w ||
                 {1'b0, chan_reg} >= cfg.in_channels ||
                 {1'b0, kr_reg} >= cfg.ker_height || {1'b0, kc_reg} >= cfg.ker_width;

    assign is_row_last = {1'b0, chan_reg} == cfg.in_channels - 5'd1 &&
                         {1'b0, kr_reg} == cfg.ker_height - 5'd1 &&
                         {1'b0, kc_reg} == cfg.ker_width - 5'd1;
    assign is_all_last = is_row_last && win_row_reg == geom.out_h - 7'd1 &&
                         win_col_reg == geom.out_w - 7'd1;

    assign kc_inc      = {1'b0, kc_reg} + 5'd1;
    assign kr_inc      = {1'b0, kr_reg} + 5'd1;
    assign chan_inc    = {1'b0, chan_reg} + 5'd1;
    assign win_col_inc = win_col_reg + 7'd1;

    // architectural counters
    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        win_row_next  = win_row_reg;
        win_col_next  = win_col_reg;
        chan_next     = chan_reg;
        kr_next       = kr_reg;
        kc_next       = kc_reg;
        done_next     = done_reg;
        emit_go       = 1'b0;
        if (state_reg == ipu_pkg::ST_IDLE && head_valid)
        begin
            case (head.req)
                ipu_pkg::REQ_LOAD:
                begin
                    if (can_load)
                    begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
                ipu_pkg::REQ_RESTART:
                begin
                    load_cnt_next = '0;
                    win_row_next  = '0;
                    win_col_next  = '0;
                    chan_next     = '0;
                    kr_next       = '0;
                    kc_next       = '0;
                    done_next     = 1'b0;
                end
                ipu_pkg::REQ_EMIT:
                begin
                    if (!geom.empty)
                    begin
                        if (bad)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            emit_go = 1'b1;
                            if (is_all_last)
                            begin
                                done_next = 1'b1;
                            end
                            else if (kc_inc != cfg.ker_width)
                            begin
                                kc_next = kc_inc[3:0];
                            end
                            else
                            begin
                                kc_next = '0;
                                if (kr_inc != cfg.ker_height)
                                begin
                                    kr_next = kr_inc[3:0];
                                end
                                else
                                begin
                                    kr_next = '0;
                                    if (chan_inc != cfg.in_channels)
                                    begin
                                        chan_next = chan_inc[3:0];
                                    end
                                    else
                                    begin
                                        chan_next = '0;
                                        if (win_col_inc != geom.out_w)
                                        begin
                                            win_col_next = win_col_inc;
                                        end
                                        else
                                        begin
                                            win_col_next = '0;
                                            win_row_next = win_row_reg + 7'd1;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        case (state_reg)
            ipu_pkg::ST_IDLE: state_next = emit_go ? ipu_pkg::ST_MUL : ipu_pkg::ST_IDLE;
            ipu_pkg::ST_MUL:  state_next = ipu_pkg::ST_SUM;
            ipu_pkg::ST_SUM:  state_next = ipu_pkg::ST_PROD;
            ipu_pkg::ST_PROD: state_next = ipu_pkg::ST_ADDR;
            ipu_pkg::ST_ADDR: state_next = ipu_pkg::ST_OUT;
            ipu_pkg::ST_OUT:  state_next = out_free ? ipu_pkg::ST_IDLE : ipu_pkg::ST_OUT;
            default:          state_next = ipu_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop      = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ipu_pkg::ST_IDLE:
            begin
                pop    = head_valid;
                ram_we = head_valid && head.req == ipu_pkg::REQ_LOAD && can_load;
            end
            ipu_pkg::ST_ADDR: ram_re = 1'b1;
            ipu_pkg::ST_OUT:  out_load = out_free;
            default: ;
        endcase
    end

    assign addr = 18'(cplane_reg) + 18'(rw_reg) + 18'(c7_reg);

    ipu_ram #(
        .WIDTH (ipu_pkg::DATA_BITS),
        .DEPTH (ipu_pkg::STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_cnt_reg[ipu_pkg::ADDR_BITS-1:0]),
        .wdata (head.pixel[ipu_pkg::DATA_BITS-1:0]),
        .re    (ram_re),
        .raddr (addr[ipu_pkg::ADDR_BITS-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ipu_pkg::ST_IDLE;
            load_cnt_reg  <= '0;
            win_row_reg   <= '0;
            win_col_reg   <= '0;
            chan_reg      <= '0;
            kr_reg        <= '0;
            kc_reg        <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            win_row_reg  <= win_row_next;
            win_col_reg  <= win_col_next;
            chan_reg     <= chan_next;
            kr_reg       <= kr_next;
            kc_reg       <= kc_next;
            done_reg     <= done_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign inside_now = !r_reg[13] && r_reg[12:0] < 13'(cfg.in_height) &&
                        !c_reg[13] && c_reg[12:0] < 13'(cfg.in_width);

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            cap_row_reg  <= win_row_reg;
            cap_col_reg  <= win_col_reg;
            cap_chan_reg <= chan_reg;
            cap_kr_reg   <= kr_reg;
            cap_kc_reg   <= kc_reg;
            row_last_reg <= is_row_last;
            all_last_reg <= is_all_last;
        end
        if (state_reg == ipu_pkg::ST_MUL)
        begin
            prod_r_reg <= 12'(cap_row_reg) * 12'(geom.stride_eff);
            prod_c_reg <= 12'(cap_col_reg) * 12'(geom.stride_eff);
            orow_reg   <= 14'(cap_row_reg) * 14'(geom.out_w);
            cm_reg     <= 9'(cap_chan_reg) * 9'(cfg.ker_height);
            cplane_reg <= 17'(cap_chan_reg) * 17'(geom.plane);
        end
        if (state_reg == ipu_pkg::ST_SUM)
        begin
            // tap position relative to the unpadded image, may go negative
            r_reg       <= 14'(prod_r_reg) + 14'(cap_kr_reg) - 14'(cfg.padding);
            c_reg       <= 14'(prod_c_reg) + 14'(cap_kc_reg) - 14'(cfg.padding);
            row_sum_reg <= 13'(orow_reg + 14'(cap_col_reg));
            col_sum_reg <= 10'(cm_reg) + 10'(cap_kr_reg);
        end
        if (state_reg == ipu_pkg::ST_PROD)
        begin
            inside_reg  <= inside_now;
            rw_reg      <= 14'(r_reg[6:0]) * 14'(cfg.in_width);
            c7_reg      <= c_reg[6:0];
            col_idx_reg <= 12'(15'(col_sum_reg) * 15'(cfg.ker_width) + 15'(cap_kc_reg));
        end
        if (state_reg == ipu_pkg::ST_ADDR)
        begin
            zero_reg <= !inside_reg || addr >= 18'(ipu_pkg::STORE_WORDS);
        end
        if (out_load)
        begin
            value_reg        <= zero_reg ? '0 : 32'(rdata);
            out_row_reg      <= row_sum_reg;
            out_col_reg      <= col_idx_reg;
            is_pad_reg       <= !inside_reg;
            row_last_out_reg <= row_last_reg;
            all_last_out_reg <= all_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign is_pad    = is_pad_reg;
    assign row_last  = row_last_out_reg;
    assign all_last  = all_last_out_reg;

    `IPU_ASSERT_IMP(a_store_write_idle, clk, rst_n, ram_we, state_reg == ipu_pkg::ST_IDLE)
    `IPU_ASSERT_NXT(a_done_after_last, clk, rst_n, out_load && all_last_reg, done_reg)

endmodule

// ===== sv/im2col_patch_unroller.sv =====
// channel  direction  handshake              payload
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in       in         in_valid / in_ready    req_type, pixel
// out      out        out_valid / out_ready  value, out_row, out_col, is_pad, row_last, all_last
//
// Accepted load, emit and restart requests enter a 4-entry queue; the back end
// drains it in order. Load and restart are handled in the back end's idle state;
// an emit passes through a counter step, three arithmetic stages, store read and
// output load. After reset and after every config write the extent divider runs
// with in_ready low. The result register frees the back end from out_ready,
// and a stalled result only holds the back end in its final state.
`include "im2col_patch_unroller_macros.svh"

module im2col_patch_unroller (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ipu_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ipu_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        req_type,
    input  logic [31:0]                       pixel,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [31:0]                       value,
    output logic [12:0]                       out_row,
    output logic [11:0]                       out_col,
    output logic                              is_pad,
    output logic                              row_last,
    output logic                              all_last
);

    ipu_pkg::cfg_t  cfg;
    ipu_pkg::geom_t geom;
    ipu_pkg::cmd_t  entry;
    ipu_pkg::cmd_t  head;
    logic           push, full, pop, head_valid;

    ipu_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .geom      (geom)
    );

    ipu_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .pixel     (pixel),
        .geom_busy (geom.busy),
        .fifo_full (full),
        .push      (push),
        .entry     (entry)
    );

    ipu_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_entry   (entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    ipu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .geom       (geom),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value),
        .out_row    (out_row),
        .out_col    (out_col),
        .is_pad     (is_pad),
        .row_last   (row_last),
        .all_last   (all_last)
    );

    `IPU_ASSERT_IMP(a_no_transfer_busy, clk, rst_n, in_valid && in_ready, !geom.busy)

endmodule
